@@ src/json_string_unescaper_assert.svh @@
// Assertion macros for the JSON string unescaper RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef JSON_STRING_UNESCAPER_ASSERT_SVH
`define JSON_STRING_UNESCAPER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescaper.
// No dependencies; the front, queue, emitter and top-level modules import this package.
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Commands from the decoder to the byte emitter
    localparam logic [2:0] OP_BYTE = 3'd0;  // one data byte in cp[7:0]
    localparam logic [2:0] OP_CP2  = 3'd1;  // two-byte UTF-8 sequence
    localparam logic [2:0] OP_CP3  = 3'd2;  // three-byte UTF-8 sequence
    localparam logic [2:0] OP_DONE = 3'd3;  // string complete
    localparam logic [2:0] OP_ERR  = 3'd4;  // error

    localparam logic [15:0] UTF8_1B_LIMIT = 16'h0080;
    localparam logic [15:0] UTF8_2B_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
    localparam logic [7:0]  UTF8_CONT     = 8'h80;
    localparam logic [7:0]  CTRL_LIMIT    = 8'h20;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] cp;
    } cmd_t;

endpackage

@@ src/jsu_in_if.sv @@
// Input channel: one raw JSON text byte per transfer.
// Depends on nothing.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_ended;

    modport source (output valid, output text_byte, output text_ended, input ready);
    modport sink   (input valid, input text_byte, input text_ended, output ready);
endinterface

@@ src/jsu_out_if.sv @@
// Output channel: one decoded result per transfer.
// Depends on nothing.
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input last_of_run,
                    output ready);
endinterface

@@ src/jsu_front.sv @@
// Decoder front: accepts text bytes, tracks string/escape/hex state, issues commands.
// Depends on jsu_pkg and jsu_in_if.
module jsu_front
    import jsu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    jsu_in_if.sink       text,
    input  logic         cmd_full,
    output logic         cmd_push,
    output cmd_t         cmd
);

    localparam logic [1:0] MODE_WAIT = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] cp_reg, cp_next;
    logic        accept;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cp_full;
    logic [7:0]  c;

    function automatic logic [4:0] hex_decode(input logic [7:0] h);
        logic [4:0] r;
        r = '0;
        if (h inside {[8'h30:8'h39]})
            r = {1'b1, 4'(h - 8'h30)};
        else if (h inside {[8'h61:8'h66]})
            r = {1'b1, 4'(h - 8'h57)};
        else if (h inside {[8'h41:8'h46]})
            r = {1'b1, 4'(h - 8'h37)};
        return r;
    endfunction

    assign c          = text.text_byte;
    assign text.ready = !cmd_full;
    assign accept     = text.valid && text.ready;
    assign {hex_ok, hex_val} = hex_decode(c);
    assign cp_full    = {cp_reg[11:0], hex_val};

    always_comb
    begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        cmd_push     = 1'b0;
        cmd.op       = OP_ERR;
        cmd.cp       = '0;
        if (accept)
        begin
            if (text.text_ended)
            begin
                cmd_push     = 1'b1;
                mode_next    = MODE_WAIT;
                hex_cnt_next = '0;
                cp_next      = '0;
            end
            else
            begin
                case (mode_reg)
                    MODE_WAIT:
                    begin
                        if (c == CH_QUOTE)
                            mode_next = MODE_STR;
                        else
                            cmd_push = 1'b1;
                    end
                    MODE_STR:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            cmd_push  = 1'b1;
                            cmd.op    = OP_DONE;
                            mode_next = MODE_WAIT;
                        end
                        else if (c == CH_BSLASH)
                            mode_next = MODE_ESC;
                        else if (c < CTRL_LIMIT)
                        begin
                            cmd_push  = 1'b1;
                            mode_next = MODE_WAIT;
                        end
                        else
                        begin
                            cmd_push = 1'b1;
                            cmd.op   = OP_BYTE;
                            cmd.cp   = {8'h00, c};
                        end
                    end
                    MODE_ESC:
                    begin
                        cmd_push  = 1'b1;
                        cmd.op    = OP_BYTE;
                        mode_next = MODE_STR;
                        case (c)
                            CH_QUOTE:  cmd.cp = {8'h00, CH_QUOTE};
                            CH_BSLASH: cmd.cp = {8'h00, CH_BSLASH};
                            CH_SLASH:  cmd.cp = {8'h00, CH_SLASH};
                            CH_B:      cmd.cp = 16'h0008;
                            CH_F:      cmd.cp = 16'h000C;
                            CH_N:      cmd.cp = 16'h000A;
                            CH_R:      cmd.cp = 16'h000D;
                            CH_T:      cmd.cp = 16'h0009;
                            CH_U:
                            begin
                                cmd_push     = 1'b0;
                                mode_next    = MODE_HEX;
                                hex_cnt_next = '0;
                                cp_next      = '0;
                            end
                            default:
                            begin
                                cmd.op    = OP_ERR;
                                mode_next = MODE_WAIT;
                            end
                        endcase
                    end
                    default:
                    begin
                        if (!hex_ok)
                        begin
                            cmd_push     = 1'b1;
                            mode_next    = MODE_WAIT;
                            hex_cnt_next = '0;
                            cp_next      = '0;
                        end
                        else if (hex_cnt_reg != 2'd3)
                        begin
                            cp_next      = cp_full;
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                        end
                        else
                        begin
                            cmd_push     = 1'b1;
                            cmd.cp       = cp_full;
                            mode_next    = MODE_STR;
                            hex_cnt_next = '0;
                            cp_next      = '0;
                            if (cp_full < UTF8_1B_LIMIT)
                                cmd.op = OP_BYTE;
                            else if (cp_full < UTF8_2B_LIMIT)
                                cmd.op = OP_CP2;
                            else
                                cmd.op = OP_CP3;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_WAIT;
            hex_cnt_reg <= '0;
            cp_reg      <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
        end
    end

endmodule

@@ src/jsu_fifo.sv @@
// Short command queue between the decoder front and the byte emitter.
// Depends on jsu_pkg.
module jsu_fifo
    import jsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign full    = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ src/jsu_back.sv @@
// Byte emitter: expands queued commands into registered results, one per unstalled cycle.
// Depends on jsu_pkg, jsu_out_if and json_string_unescaper_assert.svh.
`include "json_string_unescaper_assert.svh"

module jsu_back
    import jsu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         head,
    input  logic         empty,
    output logic         pop,
    jsu_out_if.source    result
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic [1:0] kind_reg;
    logic       last_reg;
    logic [7:0] emit_byte;
    logic [1:0] emit_kind;
    logic       emit_last;
    logic       load;

    always_comb
    begin
        emit_byte = '0;
        emit_kind = KIND_DATA;
        emit_last = 1'b1;
        case (head.op)
            OP_BYTE: emit_byte = head.cp[7:0];
            OP_CP2:
            begin
                if (idx_reg == 2'd0)
                begin
                    emit_byte = UTF8_LEAD2 | {3'b000, head.cp[10:6]};
                    emit_last = 1'b0;
                end
                else
                    emit_byte = UTF8_CONT | {2'b00, head.cp[5:0]};
            end
            OP_CP3:
            begin
                if (idx_reg == 2'd0)
                begin
                    emit_byte = UTF8_LEAD3 | {4'h0, head.cp[15:12]};
                    emit_last = 1'b0;
                end
                else if (idx_reg == 2'd1)
                begin
                    emit_byte = UTF8_CONT | {2'b00, head.cp[11:6]};
                    emit_last = 1'b0;
                end
                else
                    emit_byte = UTF8_CONT | {2'b00, head.cp[5:0]};
            end
            OP_DONE: emit_kind = KIND_DONE;
            default: emit_kind = KIND_ERROR;
        endcase
    end

    assign load = !empty && (!out_valid_reg || result.ready);
    assign pop  = load && emit_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = emit_last ? 2'd0 : idx_reg + 2'd1;
        out_valid_next = out_valid_reg && !result.ready;
        if (load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= emit_byte;
            kind_reg     <= emit_kind;
            last_reg     <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.kind        = kind_reg;
    assign result.last_of_run = last_reg;

    `JSU_ASSERT_IMPL(a_ctrl_is_last, out_valid_reg && kind_reg != KIND_DATA, last_reg,
        "end or error result not marked last")
    `JSU_ASSERT_IMPL(a_mid_seq_has_head, idx_reg != 2'd0,
        !empty && (head.op == OP_CP2 || head.op == OP_CP3),
        "sequence index advanced without a multi-byte command")
    `JSU_ASSERT_IMPL(a_third_only_cp3, idx_reg == 2'd2, head.op == OP_CP3,
        "third byte index on a non three-byte command")
    `JSU_ASSERT_NEXT(a_pop_resets_idx, pop, idx_reg == 2'd0,
        "sequence index not cleared after command retired")

endmodule

@@ src/json_string_unescaper.sv @@
// JSON string unescaper: one text byte in per cycle unless the queue is full, decoded
// UTF-8 bytes out. Inputs pass the command queue and output register before results,
// which leave at 1 per cycle while the sink is ready. A \uXXXX escape that yields 2 or
// 3 bytes holds the emitter; a 4-entry command queue absorbs those bursts.
// Reset (rst_n low, async): waiting for opening quote, queue and output register empty.
module json_string_unescaper
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    text,
    jsu_out_if.source result
);

    // Commands from the decoder into the queue
    logic cmd_push;
    cmd_t cmd;

    // Queue status and head toward the emitter
    cmd_t head;
    logic full;
    logic empty;
    logic pop;

    // Front: classify each byte; hold input off only while the queue is full.
    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .cmd_full (full),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    // Queue: decouple decode from multi-byte emission.
    jsu_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    // Back: expand each command into 1 to 3 result transfers; drop it after the last.
    jsu_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule
